>>> rtl/pcor_pkg.sv
// ----------------------------------------------------------------------------
// pcor_pkg
// shared types for the correlation block: states, multiplier ops,
// result status codes and the controller/datapath command and status groups
// ----------------------------------------------------------------------------
package pcor_pkg;

    localparam int DefMaxPairs   = 4096;
    localparam int DefSampleBits = 16;

    typedef enum logic [3:0] {
        S_ACC, S_CHECK, S_MSTART, S_MWAIT, S_ZCHK, S_QINIT, S_BIT, S_NEXT, S_RES
    } state_t;

    typedef enum logic [3:0] {
        OP_NSXY, OP_SXSY, OP_NSXX, OP_SXSX, OP_NSYY, OP_SYSY,
        OP_AB, OP_NN, OP_TT, OP_TP
    } mul_op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ZERO_VAR = 2'd1,
        ST_TOO_MANY = 2'd2
    } pcor_status_t;

    typedef struct packed {
        logic         accum;
        logic         start;
        mul_op_t      op;
        logic         q_init;
        logic         bit_dec;
        logic         clear;
        logic         load_out;
        pcor_status_t out_code;
    } pcor_cmd_t;

    typedef struct packed {
        logic mul_done;
        logic va_zero;
        logic vb_zero;
        logic ovf;
        logic cand_over;
        logic bit_zero;
        logic out_free;
    } pcor_stat_t;

    function automatic mul_op_t mul_op_next(mul_op_t op);
        mul_op_t r;
        unique case (op)
            OP_NSXY: r = OP_SXSY;
            OP_SXSY: r = OP_NSXX;
            OP_NSXX: r = OP_SXSX;
            OP_SXSX: r = OP_NSYY;
            OP_NSYY: r = OP_SYSY;
            OP_AB:   r = OP_NN;
            OP_TT:   r = OP_TP;
            default: r = OP_NSXY;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/pcor_mul.sv
// ----------------------------------------------------------------------------
// pcor_mul
// shared unsigned shift-add multiplier, one multiplier bit per cycle
// ----------------------------------------------------------------------------
module pcor_mul #(
    parameter int WA = 120,
    parameter int WB = 60
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [WA-1:0]      a,
    input  logic [WB-1:0]      b,
    output logic               done,
    output logic [WA+WB-1:0]   prod
);
    localparam int PW = WA + WB;
    localparam int CNTW = $clog2(WB);

    logic [WA-1:0]   a_reg;
    logic [WB-1:0]   b_reg;
    logic [PW-1:0]   p_reg;
    logic [CNTW-1:0] cnt_reg;
    logic            busy_reg;
    logic            done_reg;
    logic [WA:0]     sum;

    assign sum = {1'b0, p_reg[PW-1:WB]} + (b_reg[0] ? {1'b0, a_reg} : '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNTW'(WB - 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg <= a;
            b_reg <= b;
            p_reg <= '0;
        end else if (busy_reg) begin
            b_reg <= b_reg >> 1;
            p_reg <= {sum, p_reg[WB-1:1]};
        end
    end

    assign done = done_reg;
    assign prod = p_reg;

endmodule

>>> rtl/pcor_dp.sv
// ----------------------------------------------------------------------------
// pcor_dp
// accumulators, final products through the shared multiplier, bit-wise
// search of the coefficient magnitude and the result register
// ----------------------------------------------------------------------------
module pcor_dp #(
    parameter int MAX_PAIRS   = 4096,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic signed [SAMPLE_BITS-1:0] x_sample,
    input  logic signed [SAMPLE_BITS-1:0] y_sample,
    input  pcor_pkg::pcor_cmd_t           cmd,
    output pcor_pkg::pcor_stat_t          stat,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [15:0]            m_coefficient,
    output logic [1:0]                    m_status
);
    import pcor_pkg::*;

    localparam int CW  = $clog2(MAX_PAIRS + 1);
    localparam int SB  = SAMPLE_BITS;
    localparam int SXW = SB + CW;
    localparam int SPW = 2 * SB + CW;
    localparam int MW  = 2 * SB + 2 * CW + 2;
    localparam int WA  = 2 * MW;
    localparam int WB  = (MW > 32) ? MW : 32;
    localparam int PW  = WA + WB;

    logic [CW-1:0]           n_reg;
    logic signed [SXW-1:0]   sx_reg, sy_reg;
    logic signed [SPW-1:0]   sxy_reg, sxx_reg, syy_reg;
    logic                    ovf_reg;
    logic signed [MW-1:0]    t1_reg, num_reg, va_reg, vb_reg;
    logic [WA-1:0]           p_reg, nn_reg;
    logic [31:0]             tt_reg;
    logic [15:0]             q_reg;
    logic [3:0]              bit_reg;
    logic                    m_valid_reg;
    logic signed [15:0]      coef_reg;
    logic [1:0]              status_reg;

    logic signed [2*SB-1:0]  pxy, pxx, pyy;
    logic [SXW-1:0]          ax, ay;
    logic [SPW-1:0]          axy, axx, ayy;
    logic [MW-1:0]           anum;
    logic [WA-1:0]           mul_a;
    logic [WB-1:0]           mul_b;
    logic                    mul_neg;
    logic                    mul_done;
    logic [PW-1:0]           prod;
    logic signed [MW-1:0]    sres;
    logic [15:0]             cand;
    logic [15:0]             tval;
    logic signed [15:0]      coef_next;

    assign pxy = x_sample * y_sample;
    assign pxx = x_sample * x_sample;
    assign pyy = y_sample * y_sample;

    assign ax   = sx_reg[SXW-1] ? unsigned'(-sx_reg) : unsigned'(sx_reg);
    assign ay   = sy_reg[SXW-1] ? unsigned'(-sy_reg) : unsigned'(sy_reg);
    assign axy  = sxy_reg[SPW-1] ? unsigned'(-sxy_reg) : unsigned'(sxy_reg);
    assign axx  = unsigned'(sxx_reg);
    assign ayy  = unsigned'(syy_reg);
    assign anum = num_reg[MW-1] ? unsigned'(-num_reg) : unsigned'(num_reg);

    assign cand = q_reg | (16'd1 << bit_reg);
    assign tval = 16'({cand, 1'b0} - 17'd1);

    always_comb begin
        mul_a   = '0;
        mul_b   = '0;
        mul_neg = 1'b0;
        case (cmd.op)
            OP_NSXY: begin
                mul_a = WA'(axy); mul_b = WB'(n_reg); mul_neg = sxy_reg[SPW-1];
            end
            OP_SXSY: begin
                mul_a = WA'(ax); mul_b = WB'(ay); mul_neg = sx_reg[SXW-1] ^ sy_reg[SXW-1];
            end
            OP_NSXX: begin
                mul_a = WA'(axx); mul_b = WB'(n_reg);
            end
            OP_SXSX: begin
                mul_a = WA'(ax); mul_b = WB'(ax);
            end
            OP_NSYY: begin
                mul_a = WA'(ayy); mul_b = WB'(n_reg);
            end
            OP_SYSY: begin
                mul_a = WA'(ay); mul_b = WB'(ay);
            end
            OP_AB: begin
                mul_a = WA'(unsigned'(va_reg)); mul_b = WB'(unsigned'(vb_reg));
            end
            OP_NN: begin
                mul_a = WA'(anum); mul_b = WB'(anum);
            end
            OP_TT: begin
                mul_a = WA'(tval); mul_b = WB'(tval);
            end
            OP_TP: begin
                mul_a = p_reg; mul_b = WB'(tt_reg);
            end
            default: begin
                mul_a = '0;
            end
        endcase
    end

    pcor_mul #(.WA(WA), .WB(WB)) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .prod    (prod)
    );

    assign sres = mul_neg ? -signed'(prod[MW-1:0]) : signed'(prod[MW-1:0]);

    // accumulators
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear) begin
            n_reg   <= '0;
            sx_reg  <= '0;
            sy_reg  <= '0;
            sxy_reg <= '0;
            sxx_reg <= '0;
            syy_reg <= '0;
            ovf_reg <= 1'b0;
        end else if (cmd.accum) begin
            if (ovf_reg || n_reg == CW'(MAX_PAIRS)) begin
                ovf_reg <= 1'b1;
            end else begin
                n_reg   <= n_reg + 1'b1;
                sx_reg  <= sx_reg + SXW'(x_sample);
                sy_reg  <= sy_reg + SXW'(y_sample);
                sxy_reg <= sxy_reg + SPW'(pxy);
                sxx_reg <= sxx_reg + SPW'(pxx);
                syy_reg <= syy_reg + SPW'(pyy);
            end
        end
    end

    // final evaluation
    always_ff @(posedge aclk) begin
        if (cmd.q_init) begin
            q_reg   <= '0;
            bit_reg <= 4'd15;
        end else if (cmd.bit_dec) begin
            bit_reg <= bit_reg - 1'b1;
        end
        if (mul_done) begin
            case (cmd.op)
                OP_NSXY, OP_NSXX, OP_NSYY: t1_reg <= sres;
                OP_SXSY: num_reg <= t1_reg - sres;
                OP_SXSX: va_reg  <= t1_reg - sres;
                OP_SYSY: vb_reg  <= t1_reg - sres;
                OP_AB:   p_reg   <= prod[WA-1:0];
                OP_NN:   nn_reg  <= prod[WA-1:0];
                OP_TT:   tt_reg  <= prod[31:0];
                OP_TP: begin
                    if (prod <= PW'({nn_reg, 32'd0})) q_reg <= cand;
                end
                default: t1_reg <= t1_reg;
            endcase
        end
    end

    // result register
    always_comb begin
        if (cmd.out_code != ST_OK) begin
            coef_next = '0;
        end else if (num_reg[MW-1]) begin
            coef_next = signed'(16'(~q_reg + 16'd1));
        end else if (q_reg > 16'd32767) begin
            coef_next = 16'sd32767;
        end else begin
            coef_next = signed'(q_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            coef_reg   <= coef_next;
            status_reg <= cmd.out_code;
        end
    end

    assign stat.mul_done  = mul_done;
    assign stat.va_zero   = (va_reg == '0);
    assign stat.vb_zero   = (vb_reg == '0);
    assign stat.ovf       = ovf_reg;
    assign stat.cand_over = (cand > 16'd32768);
    assign stat.bit_zero  = (bit_reg == '0);
    assign stat.out_free  = !m_valid_reg || m_ready;

    assign m_valid       = m_valid_reg;
    assign m_coefficient = coef_reg;
    assign m_status      = status_reg;

endmodule

>>> rtl/pcor_ctrl.sv
// ----------------------------------------------------------------------------
// pcor_ctrl
// sequencer: accumulation, product schedule, magnitude search, result load
// ----------------------------------------------------------------------------
module pcor_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_last_pair,
    output logic                 s_ready,
    input  pcor_pkg::pcor_stat_t stat,
    output pcor_pkg::pcor_cmd_t  cmd
);
    import pcor_pkg::*;

    state_t       state_reg, state_next;
    mul_op_t      op_reg, op_next;
    pcor_status_t code_reg, code_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_ACC;
            op_reg    <= OP_NSXY;
            code_reg  <= ST_OK;
        end else begin
            state_reg <= state_next;
            op_reg    <= op_next;
            code_reg  <= code_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        code_next    = code_reg;
        s_ready      = 1'b0;
        cmd          = '0;
        cmd.op       = op_reg;
        cmd.out_code = code_reg;
        unique case (state_reg)
            S_ACC: begin
                s_ready   = 1'b1;
                cmd.accum = s_valid;
                if (s_valid && s_last_pair) state_next = S_CHECK;
            end
            S_CHECK: begin
                if (stat.ovf) begin
                    code_next  = ST_TOO_MANY;
                    state_next = S_RES;
                end else begin
                    op_next    = OP_NSXY;
                    state_next = S_MSTART;
                end
            end
            S_MSTART: begin
                cmd.start  = 1'b1;
                state_next = S_MWAIT;
            end
            S_MWAIT: begin
                if (stat.mul_done) begin
                    case (op_reg)
                        OP_SYSY: state_next = S_ZCHK;
                        OP_NN:   state_next = S_QINIT;
                        OP_TP:   state_next = S_NEXT;
                        default: begin
                            op_next    = mul_op_next(op_reg);
                            state_next = S_MSTART;
                        end
                    endcase
                end
            end
            S_ZCHK: begin
                if (stat.va_zero || stat.vb_zero) begin
                    code_next  = ST_ZERO_VAR;
                    state_next = S_RES;
                end else begin
                    op_next    = OP_AB;
                    state_next = S_MSTART;
                end
            end
            S_QINIT: begin
                cmd.q_init = 1'b1;
                code_next  = ST_OK;
                state_next = S_BIT;
            end
            S_BIT: begin
                if (stat.cand_over) begin
                    state_next = S_NEXT;
                end else begin
                    op_next    = OP_TT;
                    state_next = S_MSTART;
                end
            end
            S_NEXT: begin
                if (stat.bit_zero) begin
                    state_next = S_RES;
                end else begin
                    cmd.bit_dec = 1'b1;
                    state_next  = S_BIT;
                end
            end
            S_RES: begin
                if (stat.out_free) begin
                    cmd.load_out = 1'b1;
                    cmd.clear    = 1'b1;
                    code_next    = ST_OK;
                    state_next   = S_ACC;
                end
            end
            default: state_next = S_ACC;
        endcase
    end

endmodule

>>> rtl/pearson_correlation.sv
// ----------------------------------------------------------------------------
// pearson_correlation
// streaming correlation coefficient of paired samples, Q1.15 result
//
//   channel   direction  payload                               end of transfer
//   s_        in         x_sample, y_sample, last_pair         s_valid & s_ready
//   m_        out        coefficient, status                   m_valid & m_ready
//
// one pair per cycle while accumulating; after the last pair the input
// stalls for the evaluation, which runs on the shared shift-add multiplier
// with a WB-bit multiplier operand, WB = max(2*SAMPLE_BITS + 2*clog2(MAX_PAIRS+1) + 2, 32);
// too many pairs or zero variance end the evaluation early
// synchronous active-low reset clears all sums; a pending result does not
// stall the next sequence's pairs
// ----------------------------------------------------------------------------
module pearson_correlation #(
    parameter int MAX_PAIRS   = pcor_pkg::DefMaxPairs,
    parameter int SAMPLE_BITS = pcor_pkg::DefSampleBits
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_x_sample,
    input  logic signed [SAMPLE_BITS-1:0] s_y_sample,
    input  logic                          s_last_pair,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [15:0]            m_coefficient,
    output logic [1:0]                    m_status
);
    import pcor_pkg::*;

    pcor_cmd_t  cmd;
    pcor_stat_t stat;

    pcor_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_last_pair (s_last_pair),
        .s_ready     (s_ready),
        .stat        (stat),
        .cmd         (cmd)
    );

    pcor_dp #(.MAX_PAIRS(MAX_PAIRS), .SAMPLE_BITS(SAMPLE_BITS)) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .x_sample      (s_x_sample),
        .y_sample      (s_y_sample),
        .cmd           (cmd),
        .stat          (stat),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_coefficient (m_coefficient),
        .m_status      (m_status)
    );

    a_last_stalls: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_last_pair |=> !s_ready)
        else $error("input taken after last pair");

    a_no_code3: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status != 2'd3)
        else $error("invalid status code");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_OK |-> m_coefficient == 16'sd0)
        else $error("nonzero coefficient on error");

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> stat.out_free)
        else $error("result overwritten");

endmodule
